// ----- hdl/pcpa_pkg.sv -----
package pcpa_pkg;

    localparam int CPUS       = 8;
    localparam int PAGES      = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W = 32;
    localparam int CPU_W  = $clog2(CPUS);
    localparam int IDX_W  = $clog2(PAGES);
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int PG_W   = ADDR_W - OFF_W;
    localparam int CNT_W  = 16;
    localparam int CTR_W  = 32;
    localparam int SUM_W  = CTR_W + CPU_W;
    localparam int FSUM_W = CNT_W + CPU_W;
    localparam int TOT_CAP = (PAGES > 65535) ? 65535 : PAGES;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 176;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [ADDR_W-1:0] BASE_RESET  = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'h8800_0000;

    typedef logic [CPU_W-1:0] cpu_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_SEED,
        CMD_QUERY
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_PAGE,
        ST_BAD_ADDR
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE,
        REG_LIMIT
    } cfg_reg_t;

    typedef struct packed {
        logic found;
        cpu_t cpu;
    } pick_t;

endpackage

// ----- hdl/per_cpu_page_allocator_with_stealing_unit.sv -----
// Per-CPU LIFO page allocator with stealing. Each transaction on the input stream carries a
// command (alloc, free, seed, query), a CPU and a page address, and yields exactly one result
// with status, the allocated page and aggregate statistics taken after the command. Free, seed
// and query pass the execute and report states; an alloc that finds a page also passes the
// pop state, for the read of the 32768 x 15 link memory that holds each page's successor on
// its list. The link memory is never cleared: it is written only by free and seed. A finished
// result waits in the output register while the next transaction is taken in.
module per_cpu_page_allocator_with_stealing_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcpa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd[1:0], cpu[4:2], addr[36:5], zero fill
    input  logic [pcpa_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[1:0], page_addr[33:2], served_cpu[36:34], cpu_free_cnt[52:37],
    // managed_cnt[68:53], free_cnt[84:69], busy_cnt[100:85],
    // alloc_total[135:101], free_total[170:136], zero fill
    output logic [pcpa_pkg::OUT_W-1:0]     m_axis_tdata
);
    import pcpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_REPORT
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [ADDR_W-1:0]   limit_reg;

    cmd_t                cmd_reg;
    cpu_t                cpu_reg;
    logic                addr_ok_reg;
    idx_t                idx_reg;
    logic [CNT_W-1:0]    tot_reg;
    status_t             status_reg;
    logic [ADDR_W-1:0]   paddr_reg;
    cpu_t                served_reg;
    idx_t                pop_idx_reg;

    idx_t                list_head_reg [CPUS];
    logic [CNT_W-1:0]    list_count_reg [CPUS];
    logic [CTR_W-1:0]    alloc_ctr_reg [CPUS];
    logic [CTR_W-1:0]    free_ctr_reg [CPUS];
    cpu_t                seed_ptr_reg;
    logic [FSUM_W-1:0]   fsum_reg;
    logic [SUM_W-1:0]    alloc_sum_reg;
    logic [SUM_W-1:0]    free_sum_reg;

    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;

    // input decode and address check at accept time
    cmd_t                in_cmd;
    cpu_t                in_cpu;
    logic [ADDR_W-1:0]   in_addr;
    logic [PG_W:0]       rb_pg;
    logic [ADDR_W:0]     rb_sum;
    logic [PG_W:0]       addr_pg;
    logic [PG_W:0]       diff_pg;
    logic [PG_W:0]       lim_pg;
    logic [PG_W:0]       span_pg;
    logic                in_addr_ok;
    logic [CNT_W-1:0]    in_tot;

    logic                in_fire;
    logic                out_free;

    // execute stage
    logic [CPUS-1:0]     nonempty;
    pick_t               pick;
    logic                alloc_go;
    logic                push_go;
    cpu_t                push_cpu;
    cpu_t                exec_cpu;
    idx_t                head_sel;
    idx_t                link_rdata;
    logic [PG_W-1:0]     pop_pg;

    // report
    logic [CNT_W-1:0]    fsum_sat;
    logic [CNT_W-1:0]    used;

    assign in_cmd  = cmd_t'(s_axis_tdata[1:0]);
    assign in_cpu  = s_axis_tdata[4:2];
    assign in_addr = s_axis_tdata[36:5];

    assign rb_sum  = {1'b0, base_reg} + (ADDR_W + 1)'(PAGE_BYTES - 1);
    assign rb_pg   = rb_sum[ADDR_W:OFF_W];
    assign addr_pg = {1'b0, in_addr[ADDR_W-1:OFF_W]};
    assign diff_pg = addr_pg - rb_pg;
    assign lim_pg  = {1'b0, limit_reg[ADDR_W-1:OFF_W]};
    assign span_pg = lim_pg - rb_pg;

    assign in_addr_ok = (in_addr[OFF_W-1:0] == '0) && (addr_pg >= rb_pg)
                     && (in_addr < limit_reg) && (diff_pg < (PG_W + 1)'(PAGES));

    always_comb
    begin
        if (lim_pg < rb_pg)
        begin
            in_tot = '0;
        end
        else if (span_pg > (PG_W + 1)'(TOT_CAP))
        begin
            in_tot = CNT_W'(TOT_CAP);
        end
        else
        begin
            in_tot = span_pg[CNT_W-1:0];
        end
    end

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) || ((state_reg == S_REPORT) && out_free);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        for (int i = 0; i < CPUS; i++)
        begin
            nonempty[i] = (list_count_reg[i] != '0);
        end
    end

    pcpa_steal_pick u_pick (
        .nonempty (nonempty),
        .start    (cpu_reg),
        .pick     (pick)
    );

    assign push_cpu = (cmd_reg == CMD_SEED) ? seed_ptr_reg : cpu_reg;
    assign alloc_go = (state_reg == S_EXEC) && (cmd_reg == CMD_ALLOC) && pick.found;
    assign push_go  = (state_reg == S_EXEC) && addr_ok_reg
                   && ((cmd_reg == CMD_FREE) || (cmd_reg == CMD_SEED));
    assign exec_cpu = (cmd_reg == CMD_ALLOC) ? pick.cpu : push_cpu;
    assign head_sel = list_head_reg[exec_cpu];

    pcpa_link_ram #(
        .DEPTH  (PAGES),
        .ADDR_W (IDX_W),
        .DATA_W (IDX_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (push_go),
        .waddr (idx_reg),
        .wdata (head_sel),
        .re    (alloc_go),
        .raddr (head_sel),
        .rdata (link_rdata)
    );

    assign pop_pg = rb_pg[PG_W-1:0] + PG_W'(pop_idx_reg);

    assign fsum_sat = (fsum_reg > FSUM_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}}
                                                          : fsum_reg[CNT_W-1:0];
    assign used     = (tot_reg > fsum_sat) ? (tot_reg - fsum_sat) : '0;

    // list heads have no reset value
    always_ff @(posedge clk)
    begin
        if (push_go)
        begin
            list_head_reg[push_cpu] <= idx_reg;
        end
        else if (state_reg == S_POP)
        begin
            list_head_reg[served_reg] <= link_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= BASE_RESET;
            limit_reg     <= LIMIT_RESET;
            cmd_reg       <= CMD_QUERY;
            cpu_reg       <= '0;
            addr_ok_reg   <= 1'b0;
            idx_reg       <= '0;
            tot_reg       <= '0;
            status_reg    <= ST_OK;
            paddr_reg     <= '0;
            served_reg    <= '0;
            pop_idx_reg   <= '0;
            seed_ptr_reg  <= '0;
            fsum_reg      <= '0;
            alloc_sum_reg <= '0;
            free_sum_reg  <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            for (int i = 0; i < CPUS; i++)
            begin
                list_count_reg[i] <= '0;
                alloc_ctr_reg[i]  <= '0;
                free_ctr_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_BASE:  base_reg  <= cfg_data;
                    REG_LIMIT: limit_reg <= cfg_data;
                    default:   ;
                endcase
            end

            if (in_fire)
            begin
                cmd_reg     <= in_cmd;
                cpu_reg     <= in_cpu;
                addr_ok_reg <= in_addr_ok;
                idx_reg     <= diff_pg[IDX_W-1:0];
                tot_reg     <= in_tot;
                status_reg  <= ST_OK;
                paddr_reg   <= '0;
                served_reg  <= '0;
            end

            // in report the output register is reloaded below
            if (m_valid_reg && m_axis_tready && (state_reg != S_REPORT))
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    state_reg <= alloc_go ? S_POP : S_REPORT;
                    unique case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            if (pick.found)
                            begin
                                served_reg               <= pick.cpu;
                                pop_idx_reg              <= head_sel;
                                list_count_reg[pick.cpu] <= list_count_reg[pick.cpu] - 1'b1;
                                fsum_reg                 <= fsum_reg - 1'b1;
                                if (alloc_ctr_reg[pick.cpu] != {CTR_W{1'b1}})
                                begin
                                    alloc_ctr_reg[pick.cpu] <= alloc_ctr_reg[pick.cpu] + 1'b1;
                                    alloc_sum_reg           <= alloc_sum_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                status_reg <= ST_NO_PAGE;
                            end
                        end

                        CMD_FREE, CMD_SEED:
                        begin
                            if (addr_ok_reg)
                            begin
                                if (list_count_reg[push_cpu] != {CNT_W{1'b1}})
                                begin
                                    list_count_reg[push_cpu] <=
                                        list_count_reg[push_cpu] + 1'b1;
                                    fsum_reg <= fsum_reg + 1'b1;
                                end
                                if (cmd_reg == CMD_FREE)
                                begin
                                    if (free_ctr_reg[cpu_reg] != {CTR_W{1'b1}})
                                    begin
                                        free_ctr_reg[cpu_reg] <= free_ctr_reg[cpu_reg] + 1'b1;
                                        free_sum_reg          <= free_sum_reg + 1'b1;
                                    end
                                end
                                else if (seed_ptr_reg == cpu_t'(CPUS - 1))
                                begin
                                    seed_ptr_reg <= '0;
                                end
                                else
                                begin
                                    seed_ptr_reg <= seed_ptr_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                status_reg <= ST_BAD_ADDR;
                            end
                        end

                        CMD_QUERY: ;

                        default: ;
                    endcase
                end

                S_POP:
                begin
                    paddr_reg <= {pop_pg, {OFF_W{1'b0}}};
                    state_reg <= S_REPORT;
                end

                S_REPORT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {5'b0, free_sum_reg, alloc_sum_reg, used, fsum_sat,
                                        tot_reg, list_count_reg[cpu_reg], served_reg,
                                        paddr_reg, status_reg};
                        state_reg   <= in_fire ? S_EXEC : S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- hdl/pcpa_link_ram.sv -----
module pcpa_link_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 15
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/pcpa_steal_pick.sv -----
module pcpa_steal_pick (
    input  logic [pcpa_pkg::CPUS-1:0] nonempty,
    input  pcpa_pkg::cpu_t            start,
    output pcpa_pkg::pick_t           pick
);
    import pcpa_pkg::*;

    // circular priority: first non-empty list at or after start
    always_comb
    begin
        logic [CPU_W:0] s;
        pick = '0;
        for (int i = CPUS - 1; i >= 0; i--)
        begin
            s = {1'b0, start} + (CPU_W + 1)'(i);
            if (s >= (CPU_W + 1)'(CPUS))
            begin
                s = s - (CPU_W + 1)'(CPUS);
            end
            if (nonempty[s[CPU_W-1:0]])
            begin
                pick.found = 1'b1;
                pick.cpu   = s[CPU_W-1:0];
            end
        end
    end

endmodule

// ----- hdl/pcpa_checker.sv -----
module pcpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pcpa_pkg::OUT_W-1:0]     m_axis_tdata
);
    import pcpa_pkg::*;

    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_addr;
    logic [CPU_W-1:0]    served;
    logic [CNT_W-1:0]    cpu_free;
    logic [CNT_W-1:0]    total;
    logic [CNT_W-1:0]    free_pg;
    logic [CNT_W-1:0]    used;

    assign status    = m_axis_tdata[1:0];
    assign page_addr = m_axis_tdata[33:2];
    assign served    = m_axis_tdata[36:34];
    assign cpu_free  = m_axis_tdata[52:37];
    assign total     = m_axis_tdata[68:53];
    assign free_pg   = m_axis_tdata[84:69];
    assign used      = m_axis_tdata[100:85];

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a failed command names no page and no CPU
    a_page_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status != ST_OK) |-> (page_addr == '0) && (served == '0))
        else $error("page reported on a failed command");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (status == ST_OK) || (status == ST_NO_PAGE)
                          || (status == ST_BAD_ADDR))
        else $error("undefined status code");

    // used pages are the remainder of total over free, or zero
    a_used_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (used == '0)
                          || (({1'b0, used} + {1'b0, free_pg}) == {1'b0, total}))
        else $error("used pages inconsistent with total and free");

    a_cpu_le_free: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cpu_free <= free_pg)
        else $error("one list holds more than all lists");

endmodule

bind per_cpu_page_allocator_with_stealing_unit pcpa_checker u_pcpa_checker (.*);
